// ===== rtl/core/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 decoder: lead byte ranges, masks,
// surrogate offsets and the queued result type. No dependencies.
package u8u16_pkg;

	localparam logic [7:0]  ASCII_END     = 8'h7F;
	localparam logic [7:0]  LEAD2_LO      = 8'hC2;
	localparam logic [7:0]  LEAD2_HI      = 8'hDF;
	localparam logic [7:0]  LEAD3_LO      = 8'hE0;
	localparam logic [7:0]  LEAD3_HI      = 8'hEF;
	localparam logic [7:0]  LEAD4_LO      = 8'hF0;
	localparam logic [7:0]  LEAD4_HI      = 8'hF4;

	localparam logic [7:0]  LEAD2_MASK    = 8'h1F;
	localparam logic [7:0]  LEAD3_MASK    = 8'h0F;
	localparam logic [7:0]  LEAD4_MASK    = 8'h07;

	localparam logic [20:0] PLANE_OFFSET  = 21'h10000;
	localparam logic [15:0] HIGH_SURR     = 16'hD800;
	localparam logic [15:0] LOW_SURR      = 16'hDC00;

	localparam logic [1:0]  LEN_TWO       = 2'd1;
	localparam logic [1:0]  LEN_THREE     = 2'd2;
	localparam logic [1:0]  LEN_FOUR      = 2'd3;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        bad_lead;
		logic        last_unit;
	} unit_t;

endpackage

// ===== rtl/core/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 decoder: input register, one-pass decode, two-entry result queue.
// Depends on u8u16_pkg.
// An accepted byte passes through the input register and the result queue to the output.
// Throughput: one byte per cycle; a four-byte sequence queues two units at once,
// and the result queue (two entries) stalls the input only while it lacks room.
// Reset (arst_n low, asynchronous): no sequence open, accumulator zero, queue and
// input register empty.
module utf8_to_utf16_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] code_unit
	output logic        m_axis_tuser,   // [0] bad_lead
	output logic        m_axis_tlast    // last_unit
);

	logic              valid_s1;
	logic [7:0]        byte_s1;

	logic [1:0]        pending_q;
	logic [1:0]        seq_len_q;
	logic [20:0]       accum_q;

	u8u16_pkg::unit_t  queue_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	logic [1:0]        pending_d;
	logic [1:0]        seq_len_d;
	logic [20:0]       accum_d;
	logic [1:0]        num_res;
	u8u16_pkg::unit_t  res0;
	u8u16_pkg::unit_t  res1;
	logic [20:0]       acc_shift;
	logic [20:0]       cp_off;
	logic              pop;
	logic [2:0]        room;
	logic              adv;

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign room          = 3'd2 - {1'b0, count_q} + {2'b0, pop};
	assign adv           = valid_s1 && ({1'b0, num_res} <= room);
	assign s_axis_tready = !valid_s1 || adv;

	assign acc_shift = {accum_q[14:0], byte_s1[5:0]};
	assign cp_off    = acc_shift - u8u16_pkg::PLANE_OFFSET;

	always_comb begin
		pending_d = pending_q;
		seq_len_d = seq_len_q;
		accum_d   = accum_q;
		num_res   = 2'd0;
		res0      = '{code_unit: 16'h0000, bad_lead: 1'b0, last_unit: 1'b1};
		res1      = '{code_unit: 16'h0000, bad_lead: 1'b0, last_unit: 1'b1};
		if (pending_q == 2'd0) begin
			case (byte_s1) inside
				[8'h00 : u8u16_pkg::ASCII_END]: begin
					num_res        = 2'd1;
					res0.code_unit = {8'h00, byte_s1};
				end
				[u8u16_pkg::LEAD2_LO : u8u16_pkg::LEAD2_HI]: begin
					accum_d   = {13'h0, byte_s1 & u8u16_pkg::LEAD2_MASK};
					pending_d = u8u16_pkg::LEN_TWO;
					seq_len_d = u8u16_pkg::LEN_TWO;
				end
				[u8u16_pkg::LEAD3_LO : u8u16_pkg::LEAD3_HI]: begin
					accum_d   = {13'h0, byte_s1 & u8u16_pkg::LEAD3_MASK};
					pending_d = u8u16_pkg::LEN_THREE;
					seq_len_d = u8u16_pkg::LEN_THREE;
				end
				[u8u16_pkg::LEAD4_LO : u8u16_pkg::LEAD4_HI]: begin
					accum_d   = {13'h0, byte_s1 & u8u16_pkg::LEAD4_MASK};
					pending_d = u8u16_pkg::LEN_FOUR;
					seq_len_d = u8u16_pkg::LEN_FOUR;
				end
				default: begin
					num_res       = 2'd1;
					res0.bad_lead = 1'b1;
				end
			endcase
		end else begin
			accum_d   = acc_shift;
			pending_d = pending_q - 2'd1;
			if (pending_q == 2'd1) begin
				seq_len_d = 2'd0;
				if (seq_len_q == u8u16_pkg::LEN_FOUR) begin
					num_res        = 2'd2;
					res0.code_unit = u8u16_pkg::HIGH_SURR + {5'h00, cp_off[20:10]};
					res0.last_unit = 1'b0;
					res1.code_unit = u8u16_pkg::LOW_SURR + {6'h00, cp_off[9:0]};
				end else begin
					num_res        = 2'd1;
					res0.code_unit = acc_shift[15:0];
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			seq_len_q <= 2'd0;
			accum_q   <= 21'h0;
		end else if (adv) begin
			pending_q <= pending_d;
			seq_len_q <= seq_len_d;
			accum_q   <= accum_d;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (adv && num_res != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (adv && num_res == 2'd2) begin
			queue_q[~wr_ptr_q] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (adv) begin
				wr_ptr_q <= wr_ptr_q ^ num_res[0];
			end
			rd_ptr_q <= rd_ptr_q ^ pop;
			count_q  <= count_q + (adv ? num_res : 2'd0) - {1'b0, pop};
		end
	end

	assign m_axis_tvalid = (count_q != 2'd0);
	assign m_axis_tdata  = queue_q[rd_ptr_q].code_unit;
	assign m_axis_tuser  = queue_q[rd_ptr_q].bad_lead;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last_unit;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue overfilled");

	a_pair_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("low surrogate missing after high surrogate");

	a_pending_len: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= seq_len_q)
		else $error("pending count exceeds sequence length");

	a_closed_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_len_q == 2'd0) |-> (pending_q == 2'd0))
		else $error("bytes pending with no sequence open");

endmodule
